// ===== design/cwq_pkg.sv =====
// ----------------------------------------------------------------------------
// cwq_pkg
// Shared types and constants for the per-CPU work queue dispatcher.
// ----------------------------------------------------------------------------
package cwq_pkg;

  localparam int NUM_CPUS    = 8;
  localparam int QUEUE_SLOTS = 16;
  localparam int CPU_W       = $clog2(NUM_CPUS);
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int ADDR_W      = CPU_W + SLOT_W;
  localparam int DEPTH       = NUM_CPUS * QUEUE_SLOTS;
  localparam int DATA_W      = 64;
  localparam int TGT_W       = 6;
  localparam int CFG_CPUS_W  = 4;
  localparam int CFG_MASK_W  = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int STAT_W      = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DRAIN
  } state_t;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_ANY   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOCPU   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CPUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] whandler;
    logic [DATA_W-1:0] wargument;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== design/cwq_store.sv =====
// ----------------------------------------------------------------------------
// cwq_store
// Item store for all queues: handler and argument words, one write port and
// one registered read port, addressed by {cpu, slot}.
// ----------------------------------------------------------------------------
module cwq_store (
  input  logic                      clk,
  input  cwq_pkg::ram_req_t         req,
  output logic [cwq_pkg::DATA_W-1:0] rd_handler,
  output logic [cwq_pkg::DATA_W-1:0] rd_argument
);

  logic [cwq_pkg::DATA_W-1:0] hnd_mem [cwq_pkg::DEPTH];
  logic [cwq_pkg::DATA_W-1:0] arg_mem [cwq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      hnd_mem[req.waddr] <= req.whandler;
      arg_mem[req.waddr] <= req.wargument;
    end
    if (req.re) begin
      rd_handler  <= hnd_mem[req.raddr];
      rd_argument <= arg_mem[req.raddr];
    end
  end

endmodule

// ===== design/cwq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cwq_ctrl
// Sequencer: config registers, queue pointers, least-loaded scan through one
// shared count/compare unit, submit, query and drain control, result register.
// ----------------------------------------------------------------------------
module cwq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cwq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwq_pkg::CFG_MASK_W-1:0]  cfg_wdata,
  input  logic                            start,
  input  logic [1:0]                      kind,
  input  logic [cwq_pkg::TGT_W-1:0]       target_cpu,
  input  logic [cwq_pkg::DATA_W-1:0]      handler,
  input  logic [cwq_pkg::DATA_W-1:0]      argument,
  output logic                            busy,
  output cwq_pkg::ram_req_t               ram_req,
  output logic                            res_valid,
  output logic [cwq_pkg::STAT_W-1:0]      res_status,
  output logic [cwq_pkg::CPU_W-1:0]       res_cpu,
  output logic [cwq_pkg::SLOT_W-1:0]      res_pending,
  output logic                            res_last,
  output logic                            res_item
);

  cwq_pkg::state_t state_r, state_nxt;

  logic [cwq_pkg::CFG_CPUS_W-1:0] cpus_present_r, cpus_present_nxt;
  logic [cwq_pkg::CFG_MASK_W-1:0] online_mask_r, online_mask_nxt;

  logic [1:0]                  kind_r, kind_nxt;
  logic                        inv_r, inv_nxt;
  logic [cwq_pkg::DATA_W-1:0]  hnd_r, hnd_nxt;
  logic [cwq_pkg::DATA_W-1:0]  arg_r, arg_nxt;
  logic [cwq_pkg::CPU_W-1:0]   cpu_r, cpu_nxt;
  logic [cwq_pkg::CPU_W-1:0]   idx_r, idx_nxt;
  logic                        found_r, found_nxt;
  logic [cwq_pkg::SLOT_W-1:0]  bestn_r, bestn_nxt;

  logic [cwq_pkg::SLOT_W-1:0] rp_r  [cwq_pkg::NUM_CPUS];
  logic [cwq_pkg::SLOT_W-1:0] rp_nxt [cwq_pkg::NUM_CPUS];
  logic [cwq_pkg::SLOT_W-1:0] wp_r  [cwq_pkg::NUM_CPUS];
  logic [cwq_pkg::SLOT_W-1:0] wp_nxt [cwq_pkg::NUM_CPUS];

  logic                        valid_r, valid_nxt;
  logic [cwq_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [cwq_pkg::CPU_W-1:0]   ocpu_r, ocpu_nxt;
  logic [cwq_pkg::SLOT_W-1:0]  pend_r, pend_nxt;
  logic                        last_r, last_nxt;
  logic                        item_r, item_nxt;

  // shared unit: pointers of the selected queue, its count and compare
  logic [cwq_pkg::CPU_W-1:0]      sel;
  logic [cwq_pkg::SLOT_W-1:0]     sel_rp, sel_wp, sel_cnt, rp_inc, wp_inc, drain_left;
  logic [cwq_pkg::CFG_CPUS_W-1:0] eff;
  logic                           scan_end, part, take;

  always_comb begin
    sel        = (state_r == cwq_pkg::S_SCAN) ? idx_r : cpu_r;
    sel_rp     = rp_r[sel];
    sel_wp     = wp_r[sel];
    sel_cnt    = sel_wp - sel_rp;
    rp_inc     = sel_rp + cwq_pkg::SLOT_W'(1);
    wp_inc     = sel_wp + cwq_pkg::SLOT_W'(1);
    drain_left = sel_wp - rp_inc;
    eff        = (cpus_present_r > cwq_pkg::CFG_CPUS_W'(cwq_pkg::NUM_CPUS)) ?
                 cwq_pkg::CFG_CPUS_W'(cwq_pkg::NUM_CPUS) : cpus_present_r;
    scan_end   = (idx_r == cwq_pkg::CPU_W'(cwq_pkg::NUM_CPUS - 1));
    part       = (cwq_pkg::CFG_CPUS_W'(idx_r) < eff) && online_mask_r[idx_r];
    take       = part && (!found_r || (sel_cnt < bestn_r));
  end

  assign busy = (state_r != cwq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cwq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (kind == cwq_pkg::KIND_ANY) ? cwq_pkg::S_SCAN : cwq_pkg::S_EXEC;
        end
      end
      cwq_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = (found_r || take) ? cwq_pkg::S_EXEC : cwq_pkg::S_IDLE;
        end
      end
      cwq_pkg::S_EXEC: begin
        if (kind_r == cwq_pkg::KIND_DRAIN && !inv_r && sel_cnt != '0) begin
          state_nxt = cwq_pkg::S_DRAIN;
        end else begin
          state_nxt = cwq_pkg::S_IDLE;
        end
      end
      cwq_pkg::S_DRAIN: begin
        if (rp_inc == sel_wp) begin
          state_nxt = cwq_pkg::S_IDLE;
        end
      end
      default: state_nxt = cwq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cpus_present_nxt = cpus_present_r;
    online_mask_nxt  = online_mask_r;
    kind_nxt   = kind_r;
    inv_nxt    = inv_r;
    hnd_nxt    = hnd_r;
    arg_nxt    = arg_r;
    cpu_nxt    = cpu_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    bestn_nxt  = bestn_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    ocpu_nxt   = ocpu_r;
    pend_nxt   = pend_r;
    last_nxt   = last_r;
    item_nxt   = item_r;

    ram_req           = '0;
    ram_req.waddr     = {cpu_r, sel_wp};
    ram_req.whandler  = hnd_r;
    ram_req.wargument = arg_r;
    ram_req.raddr     = {cpu_r, sel_rp};

    if (cfg_we) begin
      case (cfg_index)
        cwq_pkg::CFG_CPUS:   cpus_present_nxt = cfg_wdata[cwq_pkg::CFG_CPUS_W-1:0];
        cwq_pkg::CFG_ONLINE: online_mask_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      cwq_pkg::S_IDLE: begin
        if (start) begin
          kind_nxt  = kind;
          hnd_nxt   = handler;
          arg_nxt   = argument;
          cpu_nxt   = target_cpu[cwq_pkg::CPU_W-1:0];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          bestn_nxt = '0;
          case (kind)
            cwq_pkg::KIND_PUT: inv_nxt = (target_cpu >= cwq_pkg::TGT_W'(eff));
            cwq_pkg::KIND_ANY: begin
              inv_nxt = 1'b0;
              cpu_nxt = '0;
            end
            default: inv_nxt = ((target_cpu >> cwq_pkg::CPU_W) != '0);
          endcase
        end
      end
      cwq_pkg::S_SCAN: begin
        idx_nxt = idx_r + cwq_pkg::CPU_W'(1);
        if (take) begin
          cpu_nxt   = idx_r;
          bestn_nxt = sel_cnt;
          found_nxt = 1'b1;
        end
        if (scan_end && !(found_r || take)) begin
          valid_nxt  = 1'b1;
          status_nxt = cwq_pkg::STAT_NOCPU;
          ocpu_nxt   = '0;
          pend_nxt   = '0;
          last_nxt   = 1'b1;
          item_nxt   = 1'b0;
        end
      end
      cwq_pkg::S_EXEC: begin
        last_nxt = 1'b1;
        item_nxt = 1'b0;
        ocpu_nxt = cpu_r;
        pend_nxt = sel_cnt;
        case (kind_r)
          cwq_pkg::KIND_PUT, cwq_pkg::KIND_ANY: begin
            valid_nxt = 1'b1;
            if (inv_r) begin
              status_nxt = cwq_pkg::STAT_INVALID;
              ocpu_nxt   = '0;
              pend_nxt   = '0;
            end else if (hnd_r == '0) begin
              status_nxt = cwq_pkg::STAT_INVALID;
            end else if (wp_inc == sel_rp) begin
              status_nxt = cwq_pkg::STAT_FULL;
            end else begin
              ram_req.we  = 1'b1;
              wp_nxt[cpu_r] = wp_inc;
              status_nxt  = cwq_pkg::STAT_OK;
              pend_nxt    = sel_cnt + cwq_pkg::SLOT_W'(1);
            end
          end
          cwq_pkg::KIND_DRAIN: begin
            if (inv_r) begin
              valid_nxt  = 1'b1;
              status_nxt = cwq_pkg::STAT_INVALID;
              ocpu_nxt   = '0;
              pend_nxt   = '0;
            end else if (sel_cnt == '0) begin
              valid_nxt  = 1'b1;
              status_nxt = cwq_pkg::STAT_EMPTY;
            end
          end
          cwq_pkg::KIND_QUERY: begin
            valid_nxt = 1'b1;
            if (inv_r) begin
              status_nxt = cwq_pkg::STAT_INVALID;
              ocpu_nxt   = '0;
              pend_nxt   = '0;
            end else begin
              status_nxt = cwq_pkg::STAT_OK;
            end
          end
          default: ;
        endcase
      end
      cwq_pkg::S_DRAIN: begin
        // item data shows up from the store together with this result
        ram_req.re    = 1'b1;
        rp_nxt[cpu_r] = rp_inc;
        valid_nxt     = 1'b1;
        status_nxt    = cwq_pkg::STAT_OK;
        ocpu_nxt      = cpu_r;
        pend_nxt      = drain_left;
        last_nxt      = (drain_left == '0);
        item_nxt      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= cwq_pkg::S_IDLE;
      cpus_present_r <= cwq_pkg::CFG_CPUS_W'(1);
      online_mask_r  <= cwq_pkg::CFG_MASK_W'(1);
      valid_r        <= 1'b0;
      for (int i = 0; i < cwq_pkg::NUM_CPUS; i++) begin
        rp_r[i] <= '0;
        wp_r[i] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      cpus_present_r <= cpus_present_nxt;
      online_mask_r  <= online_mask_nxt;
      valid_r        <= valid_nxt;
      rp_r           <= rp_nxt;
      wp_r           <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    inv_r    <= inv_nxt;
    hnd_r    <= hnd_nxt;
    arg_r    <= arg_nxt;
    cpu_r    <= cpu_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    bestn_r  <= bestn_nxt;
    status_r <= status_nxt;
    ocpu_r   <= ocpu_nxt;
    pend_r   <= pend_nxt;
    last_r   <= last_nxt;
    item_r   <= item_nxt;
  end

  assign res_valid   = valid_r;
  assign res_status  = status_r;
  assign res_cpu     = ocpu_r;
  assign res_pending = pend_r;
  assign res_last    = last_r;
  assign res_item    = item_r;

endmodule

// ===== design/per_cpu_work_queue_dispatch_core.sv =====
// ----------------------------------------------------------------------------
// per_cpu_work_queue_dispatch_core
// Per-CPU circular work queues with submit, least-loaded submit, drain and
// pending query.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the sequencer is done. Submit, query and a drain that finds nothing are
// latched, then make one pass through the pointer/count unit. Submit to the
// least loaded CPU adds a scan of one CPU per cycle through that same unit
// before that pass. A drain of N items is latched, passes through that unit,
// then gives one item per cycle through the single store read port. Each
// result sits on the out_ ports for one cycle while out_valid is high; there
// is no backpressure, so the receiver must take every result as it comes.
// The result of one item may still be showing while the next item is taken.
module per_cpu_work_queue_dispatch_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cwq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwq_pkg::CFG_MASK_W-1:0]  cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [cwq_pkg::TGT_W-1:0]       in_target_cpu,
  input  logic [cwq_pkg::DATA_W-1:0]      in_handler,
  input  logic [cwq_pkg::DATA_W-1:0]      in_argument,
  output logic                            out_valid,
  output logic [cwq_pkg::STAT_W-1:0]      out_status,
  output logic [cwq_pkg::CPU_W-1:0]       out_chosen_cpu,
  output logic [cwq_pkg::DATA_W-1:0]      out_item_handler,
  output logic [cwq_pkg::DATA_W-1:0]      out_item_argument,
  output logic [cwq_pkg::SLOT_W-1:0]      out_pending_count,
  output logic                            out_last
);

  cwq_pkg::ram_req_t          ram_req;
  logic [cwq_pkg::DATA_W-1:0] rd_handler, rd_argument;
  logic                       res_item;

  cwq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .kind        (in_kind),
    .target_cpu  (in_target_cpu),
    .handler     (in_handler),
    .argument    (in_argument),
    .busy        (busy),
    .ram_req     (ram_req),
    .res_valid   (out_valid),
    .res_status  (out_status),
    .res_cpu     (out_chosen_cpu),
    .res_pending (out_pending_count),
    .res_last    (out_last),
    .res_item    (res_item)
  );

  cwq_store u_store (
    .clk         (clk),
    .req         (ram_req),
    .rd_handler  (rd_handler),
    .rd_argument (rd_argument)
  );

  // item words are zero on every result that is not a drained item
  assign out_item_handler  = res_item ? rd_handler  : '0;
  assign out_item_argument = res_item ? rd_argument : '0;

endmodule

// ===== test/tb_per_cpu_work_queue_dispatch_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_cpu_work_queue_dispatch_core
// Checks the per-CPU work queue dispatcher against a cycle-free software copy
// of its queues: directed submit/drain/query cases, register extremes, a full
// queue, then random traffic under several register settings with random
// gaps on the command side. Every result strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb_per_cpu_work_queue_dispatch_core;
  import cwq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [CPU_W-1:0]  cpu;
    logic [DATA_W-1:0] handler;
    logic [DATA_W-1:0] argument;
    logic [SLOT_W-1:0] pending;
    logic              last;
  } dispatch_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CPUS;
  logic [CFG_MASK_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_kind = KIND_QUERY;
  logic [TGT_W-1:0]      in_target_cpu = '0;
  logic [DATA_W-1:0]     in_handler = '0;
  logic [DATA_W-1:0]     in_argument = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [CPU_W-1:0]      out_chosen_cpu;
  logic [DATA_W-1:0]     out_item_handler;
  logic [DATA_W-1:0]     out_item_argument;
  logic [SLOT_W-1:0]     out_pending_count;
  logic                  out_last;

  per_cpu_work_queue_dispatch_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_target_cpu     (in_target_cpu),
    .in_handler        (in_handler),
    .in_argument       (in_argument),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_chosen_cpu    (out_chosen_cpu),
    .out_item_handler  (out_item_handler),
    .out_item_argument (out_item_argument),
    .out_pending_count (out_pending_count),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Software copy of the queues and registers
  logic [CFG_CPUS_W-1:0] present_cpus;
  logic [CFG_MASK_W-1:0] online_cpus;
  logic [SLOT_W-1:0]     ring_rd [NUM_CPUS];
  logic [SLOT_W-1:0]     ring_wr [NUM_CPUS];
  logic [DATA_W-1:0]     ring_handler [NUM_CPUS][QUEUE_SLOTS];
  logic [DATA_W-1:0]     ring_argument [NUM_CPUS][QUEUE_SLOTS];

  dispatch_result_t dispatch_due [$];
  dispatch_result_t due_head;
  int               mismatches = 0;
  int               cycles = 0;
  bit               gaps_on = 1'b1;

  function automatic logic [SLOT_W-1:0] queued(int c);
    return ring_wr[c] - ring_rd[c];
  endfunction

  task automatic due(input logic [STAT_W-1:0] st, input int cpu, input logic [DATA_W-1:0] h,
                     input logic [DATA_W-1:0] a, input logic [SLOT_W-1:0] pend,
                     input logic last);
    dispatch_result_t r;
    r.status   = st;
    r.cpu      = cpu[CPU_W-1:0];
    r.handler  = h;
    r.argument = a;
    r.pending  = pend;
    r.last     = last;
    dispatch_due.push_back(r);
  endtask

  task automatic ring_put(input int c, input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] a);
    if (h == '0) begin
      due(STAT_INVALID, c, '0, '0, queued(c), 1'b1);
    end else if (SLOT_W'(ring_wr[c] + 1) == ring_rd[c]) begin
      due(STAT_FULL, c, '0, '0, queued(c), 1'b1);
    end else begin
      ring_handler[c][ring_wr[c]]  = h;
      ring_argument[c][ring_wr[c]] = a;
      ring_wr[c] = ring_wr[c] + 1'b1;
      due(STAT_OK, c, '0, '0, queued(c), 1'b1);
    end
  endtask

  task automatic predict_dispatch(input logic [1:0] kind, input logic [TGT_W-1:0] tc,
                                  input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] a);
    int          eff;
    int          best;
    bit          found;
    logic [SLOT_W-1:0] n;
    logic [SLOT_W-1:0] best_n;
    int          c;
    eff = (present_cpus > NUM_CPUS) ? NUM_CPUS : int'(present_cpus);
    c = int'(tc);
    case (kind)
      KIND_PUT: begin
        if (c >= eff) due(STAT_INVALID, 0, '0, '0, '0, 1'b1);
        else ring_put(c, h, a);
      end
      KIND_ANY: begin
        found = 1'b0;
        best = 0;
        best_n = '0;
        for (int i = 0; i < eff; i++) begin
          if (online_cpus[i]) begin
            n = queued(i);
            if (!found || n < best_n) begin
              found = 1'b1;
              best = i;
              best_n = n;
            end
          end
        end
        if (!found) due(STAT_NOCPU, 0, '0, '0, '0, 1'b1);
        else ring_put(best, h, a);
      end
      default: begin
        if (c >= NUM_CPUS) begin
          due(STAT_INVALID, 0, '0, '0, '0, 1'b1);
        end else if (kind == KIND_QUERY) begin
          due(STAT_OK, c, '0, '0, queued(c), 1'b1);
        end else if (ring_rd[c] == ring_wr[c]) begin
          due(STAT_EMPTY, c, '0, '0, '0, 1'b1);
        end else begin
          while (ring_rd[c] != ring_wr[c]) begin
            n = ring_rd[c];
            ring_rd[c] = ring_rd[c] + 1'b1;
            due(STAT_OK, c, ring_handler[c][n], ring_argument[c][n], queued(c),
                queued(c) == '0);
          end
        end
      end
    endcase
  endtask

  // Result checker: the receiver takes every strobe as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (dispatch_due.size() == 0) begin
        $error("result strobe with nothing outstanding (status %0d cpu %0d)",
               out_status, out_chosen_cpu);
        mismatches++;
      end else begin
        due_head = dispatch_due.pop_front();
        if (out_status !== due_head.status) begin
          $error("status: expected %0d, got %0d", due_head.status, out_status);
          mismatches++;
        end
        if (out_chosen_cpu !== due_head.cpu) begin
          $error("chosen_cpu: expected %0d, got %0d", due_head.cpu, out_chosen_cpu);
          mismatches++;
        end
        if (out_item_handler !== due_head.handler) begin
          $error("item_handler: expected %h, got %h", due_head.handler, out_item_handler);
          mismatches++;
        end
        if (out_item_argument !== due_head.argument) begin
          $error("item_argument: expected %h, got %h", due_head.argument, out_item_argument);
          mismatches++;
        end
        if (out_pending_count !== due_head.pending) begin
          $error("pending_count: expected %0d, got %0d", due_head.pending, out_pending_count);
          mismatches++;
        end
        if (out_last !== due_head.last) begin
          $error("last: expected %0d, got %0d", due_head.last, out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One command transfer; called at a rising edge
  task automatic send_op(input logic [1:0] kind, input logic [TGT_W-1:0] tc,
                         input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] a);
    int gap;
    start         <= 1'b1;
    in_kind       <= kind;
    in_target_cpu <= tc;
    in_handler    <= h;
    in_argument   <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_dispatch(kind, tc, h, a);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes only once the block has drained and gone idle
  task automatic write_dispatch_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_MASK_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (dispatch_due.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CPUS) present_cpus = val[CFG_CPUS_W-1:0];
    else online_cpus = val;
  endtask

  function automatic logic [DATA_W-1:0] rand_word(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + 5) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_random_op();
    int r;
    logic [1:0]       kind;
    logic [TGT_W-1:0] tc;
    r = $urandom_range(0, 99);
    if (r < 35) kind = KIND_PUT;
    else if (r < 60) kind = KIND_ANY;
    else if (r < 78) kind = KIND_DRAIN;
    else kind = KIND_QUERY;
    if ($urandom_range(0, 99) < 80) tc = TGT_W'($urandom_range(0, 9));
    else tc = TGT_W'($urandom_range(0, 63));
    send_op(kind, tc, rand_word(8), rand_word(5));
  endtask

  // Reset values: one CPU present, CPU 0 online
  task automatic test_reset_defaults();
    send_op(KIND_QUERY, 6'd0, '0, '0);
    send_op(KIND_PUT, 6'd0, '1, '1);
    send_op(KIND_PUT, 6'd0, 64'd1, '0);
    send_op(KIND_PUT, 6'd1, 64'hA5A5_A5A5_A5A5_A5A5, '0);
    send_op(KIND_PUT, 6'd63, 64'h5A5A_5A5A_5A5A_5A5A, '1);
    send_op(KIND_PUT, 6'd0, '0, 64'h1234);
    send_op(KIND_ANY, 6'd63, 64'h8000_0000_0000_0000, 64'hA5A5_A5A5_A5A5_A5A5);
    send_op(KIND_ANY, 6'd0, '0, '1);
    send_op(KIND_QUERY, 6'd7, '0, '0);
    send_op(KIND_QUERY, 6'd8, '0, '0);
    send_op(KIND_DRAIN, 6'd0, '0, '0);
    send_op(KIND_DRAIN, 6'd0, '0, '0);
    send_op(KIND_DRAIN, 6'd63, '0, '0);
    send_op(KIND_DRAIN, 6'd5, '0, '0);
  endtask

  // No CPU present / none online, count above NUM_CPUS, ties
  task automatic test_register_extremes();
    write_dispatch_reg(CFG_CPUS, 8'd0);
    send_op(KIND_PUT, 6'd0, 64'd7, 64'd7);
    send_op(KIND_ANY, 6'd0, 64'd7, 64'd7);
    send_op(KIND_ANY, 6'd0, '0, 64'd7);
    send_op(KIND_QUERY, 6'd0, '0, '0);
    write_dispatch_reg(CFG_CPUS, 8'd8);
    write_dispatch_reg(CFG_ONLINE, 8'h00);
    send_op(KIND_ANY, 6'd0, 64'd9, 64'd9);
    write_dispatch_reg(CFG_ONLINE, 8'h80);
    send_op(KIND_ANY, 6'd0, 64'd10, 64'd11);
    write_dispatch_reg(CFG_CPUS, 8'd15);
    send_op(KIND_ANY, 6'd0, 64'd12, 64'd13);
    send_op(KIND_PUT, 6'd7, 64'd14, 64'd15);
    write_dispatch_reg(CFG_ONLINE, 8'hFF);
    send_op(KIND_ANY, 6'd0, 64'd16, 64'd17);
    send_op(KIND_ANY, 6'd0, 64'd18, 64'd19);
    send_op(KIND_ANY, 6'd0, 64'd20, 64'd21);
    send_op(KIND_DRAIN, 6'd7, '0, '0);
  endtask

  // Fill one queue past capacity through least-loaded submits, then drain it
  task automatic test_queue_full();
    write_dispatch_reg(CFG_CPUS, 8'd8);
    write_dispatch_reg(CFG_ONLINE, 8'h08);
    send_op(KIND_DRAIN, 6'd3, '0, '0);
    repeat (QUEUE_SLOTS) send_op(KIND_ANY, 6'd0, {$urandom, $urandom} | 64'd1,
                                 {$urandom, $urandom});
    send_op(KIND_PUT, 6'd3, 64'd1, 64'd2);
    send_op(KIND_PUT, 6'd3, '0, 64'd2);
    send_op(KIND_QUERY, 6'd3, '0, '0);
    send_op(KIND_DRAIN, 6'd3, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_MASK_W-1:0] cpus_val;
    logic [CFG_MASK_W-1:0] mask_val;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin cpus_val = 8'd8;  mask_val = 8'hFF; end
        1: begin cpus_val = 8'd1;  mask_val = 8'h01; end
        2: begin cpus_val = 8'd0;  mask_val = 8'hFF; end
        3: begin cpus_val = 8'd15; mask_val = 8'hAA; end
        4: begin cpus_val = 8'd8;  mask_val = 8'h00; end
        5: begin cpus_val = 8'd4;  mask_val = 8'h0F; end
        6: begin cpus_val = 8'd8;  mask_val = 8'h81; end
        default: begin
          cpus_val = CFG_MASK_W'($urandom_range(0, 15));
          mask_val = CFG_MASK_W'($urandom);
        end
      endcase
      write_dispatch_reg(CFG_CPUS, cpus_val);
      write_dispatch_reg(CFG_ONLINE, mask_val);
      gaps_on = (p % 4) != 1;
      repeat (36) send_random_op();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    present_cpus = 4'd1;
    online_cpus  = 8'd1;
    for (int c = 0; c < NUM_CPUS; c++) begin
      ring_rd[c] = '0;
      ring_wr[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_queue_full();
    test_random_traffic();

    start <= 1'b0;
    for (int n = 0; n < 5000 && dispatch_due.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (dispatch_due.size() != 0) begin
      $error("%0d results never arrived", dispatch_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
